@@ rtl/pwr_pkg.sv @@
// Package for the particle weight resampler: sequencer states, request and
// status codes, register indexes. No dependencies.
package pwr_pkg;

   typedef enum logic [1:0] {
      REQ_LOAD     = 2'd0,
      REQ_REWEIGHT = 2'd1,
      REQ_DRAW     = 2'd2,
      REQ_NONE     = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RESAMPLE = 2'd1,
      ST_LOST     = 2'd2,
      ST_DRAW     = 2'd3
   } status_code_type;

   localparam logic [1:0] CSR_ACTIVE   = 2'd0;
   localparam logic [1:0] CSR_LOST     = 2'd1;
   localparam logic [1:0] CSR_RESAMPLE = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RW_RD,     // read addressed weight for reweight
      S_RW_WAIT,
      S_RW_MUL,    // register product
      S_RW_WR,
      S_SUM_RD,    // sweep: accumulate sum
      S_SUM_ACC,
      S_NRM_RD,    // sweep: divide each weight by the sum
      S_NRM_LD,
      S_NRM_DIV,
      S_NRM_SQ,    // square product
      S_NRM_WR,
      S_NEFF_DIV,  // reciprocal of sum of squares
      S_CLASS,
      S_DRW_RD,
      S_DRW_CHK,
      S_DONE
   } state_type;

endpackage

@@ rtl/pwr_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module pwr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

@@ rtl/particle_weight_resampler_unit.sv @@
// Top level of the particle weight resampler: sequencer, shared divider,
// multiplier and adder around one weight RAM. Uses pwr_pkg and pwr_ram.
//
// channel | ports                        | handshake
// --------+------------------------------+-------------------------------
// request | req_* fields                 | start & !busy accepts a word
// result  | rsp_* fields                 | rsp_valid one cycle, no stall
// config  | csr_wr_en, csr_index, data   | written at any edge with enable
//
// A pass end sweeps the n active weights twice, with a WEIGHT_BITS-step
// restoring divide for each weight below a nonzero sum. A draw makes one
// RAM read per weight that it walks. The divide is bit-serial and the RAM
// has a single port. Reset is synchronous; no clearing pass.
// Results cannot stall.
module particle_weight_resampler_unit
   import pwr_pkg::*;
#(
   parameter int MAX_PARTICLES = 512,
   parameter int WEIGHT_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [8:0]  req_particle_index,
   input  logic [31:0] req_weight_in,
   input  logic [15:0] req_likelihood_in,
   input  logic [31:0] req_uniform_in,
   input  logic        req_pass_end,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [8:0]  rsp_picked_index,
   output logic [31:0] rsp_picked_weight,
   output logic [9:0]  rsp_effective_size,
   output logic [8:0]  rsp_best_index,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);
   localparam int AW = $clog2(MAX_PARTICLES);
   localparam int NW = $clog2(MAX_PARTICLES + 1);
   localparam int WB = WEIGHT_BITS;
   localparam int SW = WB + NW;           // sum width
   localparam int CW = $clog2(WB + 1);
   localparam logic [WB-1:0] WMAX = '1;
   localparam logic [NW-1:0] NMAX = NW'(MAX_PARTICLES);

   // configuration registers
   logic [9:0] active_ff;
   logic [7:0] lostf_ff, resf_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 10'd500;
         lostf_ff  <= 8'd10;
         resf_ff   <= 8'd192;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ACTIVE:   active_ff <= csr_data;
            CSR_LOST:     lostf_ff  <= csr_data[7:0];
            CSR_RESAMPLE: resf_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // clamp active count to 1..MAX_PARTICLES
   logic [NW-1:0] n_cnt;
   always_comb begin
      if (active_ff == 10'd0) begin
         n_cnt = NW'(1);
      end else if (32'(active_ff) > MAX_PARTICLES) begin
         n_cnt = NMAX;
      end else begin
         n_cnt = NW'(active_ff);
      end
   end

   // Q0.32 to Q0.WB and back
   function automatic logic [WB-1:0] from_q32(input logic [31:0] v);
      logic [79:0] t;
      t = {v, 48'd0};
      return t[79 -: WB];
   endfunction
   function automatic logic [31:0] to_q32(input logic [WB-1:0] v);
      logic [WB+31:0] t;
      t = {v, 32'd0};
      return t[WB+31 -: 32];
   endfunction

   // state and working registers
   state_type           state_ff, state_in;
   logic [1:0]          req_ff, req_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic                idx_ok_ff, idx_ok_in;
   logic [WB-1:0]       wval_ff, wval_in;     // weight or load value
   logic [15:0]         lik_ff, lik_in;
   logic                pend_ff, pend_in;
   logic [SW-1:0]       sum_ff, sum_in;       // weight sum / draw remainder
   logic [SW-1:0]       sq_ff, sq_in;         // sum of squares
   logic [NW-1:0]       cnt_ff, cnt_in;
   logic [SW-1:0]       rem_ff, rem_in;       // divider remainder
   logic [WB-1:0]       quo_ff, quo_in;
   logic [CW-1:0]       step_ff, step_in;
   logic                any_ff, any_in;
   logic [WB-1:0]       bestw_ff, bestw_in;
   logic [AW-1:0]       bidx_ff, bidx_in;
   logic [2*WB-1:0]     prod_ff, prod_in;
   logic                lost_ff, lost_in;
   logic [8:0]          best_ff, best_in;
   logic [9:0]          neff_ff, neff_in;
   logic                ovf_ff, ovf_in;       // neff quotient too big
   logic                rv_ff, rv_in;
   logic [1:0]          rst_ff, rst_in;
   logic [8:0]          rpi_ff, rpi_in;
   logic [31:0]         rpw_ff, rpw_in;

   // RAM port
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [WB-1:0] ram_wd, ram_rd;

   pwr_ram #(.WIDTH(WB), .DEPTH(MAX_PARTICLES)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lost_ff  <= 1'b0;
         best_ff  <= '0;
         neff_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         lost_ff  <= lost_in;
         best_ff  <= best_in;
         neff_ff  <= neff_in;
         rv_ff    <= rv_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      idx_ok_ff <= idx_ok_in;
      wval_ff   <= wval_in;
      lik_ff    <= lik_in;
      pend_ff   <= pend_in;
      sum_ff    <= sum_in;
      sq_ff     <= sq_in;
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      any_ff    <= any_in;
      bestw_ff  <= bestw_in;
      bidx_ff   <= bidx_in;
      prod_ff   <= prod_in;
      ovf_ff    <= ovf_in;
      rst_ff    <= rst_in;
      rpi_ff    <= rpi_in;
      rpw_ff    <= rpw_in;
   end

   // shared divider step: remainder doubles, subtract divisor when it fits
   logic [SW-1:0] div_den;
   logic [SW:0]   div_sh;
   logic          div_fit;
   always_comb begin
      div_den = (state_ff == S_NEFF_DIV) ? sq_ff : sum_ff;
      div_sh  = (SW + 1)'({rem_ff, 1'b0});
      div_fit = div_sh >= {1'b0, div_den};
   end

   // neff thresholds
   logic [NW+8:0] neff_x256, lim_lost, lim_res;
   assign neff_x256 = (NW + 9)'(neff_ff) << 8;
   assign lim_lost  = (NW + 9)'(n_cnt * lostf_ff);
   assign lim_res   = (NW + 9)'(n_cnt * resf_ff);

   logic [SW-1:0] rdw;
   assign rdw = SW'(ram_rd);
   logic [AW-1:0] cnt_a;
   assign cnt_a = cnt_ff[AW-1:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      req_in = req_ff; idx_in = idx_ff; idx_ok_in = idx_ok_ff;
      wval_in = wval_ff; lik_in = lik_ff; pend_in = pend_ff;
      sum_in = sum_ff; sq_in = sq_ff; cnt_in = cnt_ff;
      rem_in = rem_ff; quo_in = quo_ff; step_in = step_ff;
      any_in = any_ff; bestw_in = bestw_ff; bidx_in = bidx_ff;
      prod_in = prod_ff; lost_in = lost_ff; best_in = best_ff;
      neff_in = neff_ff; ovf_in = ovf_ff;
      rv_in = 1'b0; rst_in = rst_ff; rpi_in = rpi_ff; rpw_in = rpw_ff;
      ram_we = 1'b0; ram_addr = cnt_a; ram_wd = wval_ff;

      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               req_in    = req_type;
               idx_in    = AW'(req_particle_index);
               idx_ok_in = 32'(req_particle_index) < MAX_PARTICLES;
               wval_in   = from_q32(req_weight_in);
               lik_in    = req_likelihood_in;
               pend_in   = req_pass_end;
               sum_in    = SW'(from_q32(req_uniform_in));
               cnt_in    = '0;
               rst_in    = ST_OK;
               rpi_in    = '0;
               rpw_in    = '0;
               case (req_type)
                  REQ_LOAD: begin
                     lost_in = 1'b0;
                     state_in = S_DONE;
                     ram_we   = 32'(req_particle_index) < MAX_PARTICLES;
                     ram_addr = AW'(req_particle_index);
                     ram_wd   = from_q32(req_weight_in);
                  end
                  REQ_REWEIGHT: state_in = S_RW_RD;
                  REQ_DRAW:     state_in = S_DRW_RD;
                  default:      state_in = S_DONE;
               endcase
            end
         end
         S_RW_RD: begin
            ram_addr = idx_ff;
            state_in = S_RW_WAIT;
         end
         S_RW_WAIT: begin
            ram_addr = idx_ff;
            state_in = S_RW_MUL;
         end
         S_RW_MUL: begin
            prod_in  = (2*WB)'(ram_rd) * (2*WB)'(lik_ff);
            state_in = S_RW_WR;
         end
         S_RW_WR: begin
            ram_addr = idx_ff;
            ram_we   = idx_ok_ff;
            ram_wd   = prod_ff[WB+15:16];
            cnt_in   = '0;
            sum_in   = '0;
            state_in = pend_ff ? S_SUM_RD : S_DONE;
         end
         // sweep one: sum of active weights
         S_SUM_RD: begin
            state_in = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            sum_in = sum_ff + rdw;
            if (cnt_ff == n_cnt - NW'(1)) begin
               cnt_in = '0; sq_in = '0; any_in = 1'b0;
               bestw_in = '0; bidx_in = best_ff[AW-1:0];
               state_in = S_NRM_RD;
            end else begin
               cnt_in = cnt_ff + NW'(1);
               state_in = S_SUM_RD;
            end
         end
         // sweep two: normalize, square, track best
         S_NRM_RD: begin
            state_in = S_NRM_LD;
         end
         S_NRM_LD: begin
            rem_in  = SW'(ram_rd);
            quo_in  = '0;
            step_in = '0;
            if (sum_ff == '0) begin
               quo_in = '0;
               state_in = S_NRM_SQ;
            end else if (rdw >= sum_ff) begin
               quo_in = WMAX;
               state_in = S_NRM_SQ;
            end else begin
               state_in = S_NRM_DIV;
            end
         end
         S_NRM_DIV: begin
            quo_in = {quo_ff[WB-2:0], div_fit};
            rem_in = SW'(div_fit ? div_sh - {1'b0, div_den} : div_sh);
            step_in = step_ff + CW'(1);
            if (step_ff == CW'(WB - 1)) state_in = S_NRM_SQ;
         end
         S_NRM_SQ: begin
            prod_in = (2*WB)'(quo_ff) * (2*WB)'(quo_ff);
            if (quo_ff != '0) any_in = 1'b1;
            if (quo_ff > bestw_ff) begin
               bestw_in = quo_ff;
               bidx_in  = cnt_a;
            end
            state_in = S_NRM_WR;
         end
         S_NRM_WR: begin
            ram_we = 1'b1;
            ram_wd = quo_ff;
            sq_in  = sq_ff + SW'(prod_ff[2*WB-1:WB]);
            if (cnt_ff == n_cnt - NW'(1)) begin
               // reciprocal: 2^WB / sq, quotient capped by n
               rem_in  = SW'(1);
               quo_in  = '0;
               step_in = '0;
               ovf_in  = 1'b0;
               state_in = S_NEFF_DIV;
            end else begin
               cnt_in = cnt_ff + NW'(1);
               state_in = S_NRM_RD;
            end
         end
         S_NEFF_DIV: begin
            if (sq_ff == '0) begin
               neff_in  = any_ff ? 10'(n_cnt) : 10'd0;
               state_in = S_CLASS;
            end else begin
               quo_in  = {quo_ff[WB-2:0], div_fit};
               if (quo_ff[WB-1]) ovf_in = 1'b1;
               rem_in  = SW'(div_fit ? div_sh - {1'b0, div_den} : div_sh);
               step_in = step_ff + CW'(1);
               if (step_ff == CW'(WB - 1)) begin
                  // quotient of 2^WB / sq taken over WB steps
                  if (ovf_ff || quo_ff[WB-1] || {quo_ff[WB-2:0], div_fit} > WB'(n_cnt))
                     neff_in = 10'(n_cnt);
                  else
                     neff_in = 10'({quo_ff[WB-2:0], div_fit});
                  if (!any_ff) neff_in = 10'd0;
                  state_in = S_CLASS;
               end
            end
         end
         S_CLASS: begin
            if (neff_x256 < lim_lost) begin
               lost_in = 1'b1;
            end else if (neff_x256 < lim_res) begin
               rst_in = ST_RESAMPLE;
            end
            if (lost_ff || neff_x256 < lim_lost) begin
               rst_in = ST_LOST;
            end else if (bestw_ff != '0) begin
               best_in = 9'(bidx_ff);
            end
            state_in = S_DONE;
         end
         // draw: walk cumulative weights
         S_DRW_RD: begin
            state_in = S_DRW_CHK;
         end
         S_DRW_CHK: begin
            if (sum_ff <= rdw || cnt_ff == n_cnt - NW'(1)) begin
               rst_in = ST_DRAW;
               rpi_in = 9'(cnt_a);
               rpw_in = to_q32(ram_rd);
               state_in = S_DONE;
            end else begin
               sum_in = sum_ff - rdw;
               cnt_in = cnt_ff + NW'(1);
               state_in = S_DRW_RD;
            end
         end
         S_DONE: begin
            if (req_ff == REQ_DRAW) rst_in = ST_DRAW;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy               = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid          = rv_ff;
   assign rsp_status         = rst_ff;
   assign rsp_picked_index   = rpi_ff;
   assign rsp_picked_weight  = rpw_ff;
   assign rsp_effective_size = neff_ff;
   assign rsp_best_index     = best_ff;
endmodule

@@ rtl/pwr_checker.sv @@
// Port-level checks for the particle weight resampler.
// Depends on pwr_pkg; bound to particle_weight_resampler_unit.
module pwr_checker
   import pwr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_type,
   input logic       rsp_valid,
   input logic [1:0] rsp_status
);
   // a result word never arrives while the block is idle
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   // an accepted item keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accept without busy");
   // results are single-cycle strobes
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held");
   // a load returns status ok
   a_load_ok: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type == REQ_LOAD |=> ##1 rsp_valid && rsp_status == ST_OK)
      else $error("load status");
endmodule

bind particle_weight_resampler_unit pwr_checker u_pwr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_type  (req_type),
   .rsp_valid (rsp_valid),
   .rsp_status(rsp_status)
);

@@ verif/testbench.sv @@
// Self-checking testbench for particle_weight_resampler_unit: directed table,
// then randomized load/reweight/draw sequences checked against a weight predictor.
// Depends on rtl/pwr_pkg.sv and rtl/particle_weight_resampler_unit.sv.
module testbench;
   import pwr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPART      = 512;
   localparam int CYCLE_CAP  = 4000000;
   localparam int ITEM_GOAL  = 1150;

   typedef struct {
      req_code_type kind;
      bit [8:0]     index;
      bit [31:0]    weight;
      bit [15:0]    likelihood;
      bit [31:0]    uniform;
      bit           pass_end;
   } word_type;

   typedef struct {
      status_code_type status;
      bit [8:0]        picked_index;
      bit [31:0]       picked_weight;
      bit [9:0]        eff_size;
      bit [8:0]        best;
   } verdict_type;

   typedef struct {
      bit          is_csr;
      logic [1:0]  csr_sel;
      bit [9:0]    csr_value;
      word_type    wd;
      bit          typed;
      verdict_type typed_res;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = '0;
   logic [8:0]  req_particle_index = '0;
   logic [31:0] req_weight_in = '0;
   logic [15:0] req_likelihood_in = '0;
   logic [31:0] req_uniform_in = '0;
   logic        req_pass_end = 1'b0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [8:0]  rsp_picked_index;
   logic [31:0] rsp_picked_weight;
   logic [9:0]  rsp_effective_size;
   logic [8:0]  rsp_best_index;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [9:0]  csr_data = '0;

   particle_weight_resampler_unit i_dut (.*);

   // predictor state
   bit [31:0] weights [NPART];
   bit        track_lost;
   bit [8:0]  best_pick;
   bit [9:0]  eff_size_q;
   bit [9:0]  cfg_active;
   bit [7:0]  cfg_lost_q8;
   bit [7:0]  cfg_resample_q8;

   verdict_type pending_q[$];
   row_type     stim_table[$];
   int          err_cnt = 0;
   int          words_sent = 0;
   int          cycle_cnt = 0;
   int          gap_max = 18;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // abort on a hung run
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int live_count();
      int n;
      n = cfg_active;
      if (n < 1) n = 1;
      if (n > NPART) n = NPART;
      return n;
   endfunction

   // normalize, effective size, best particle and track class at pass end
   function automatic status_code_type close_pass();
      int n;
      bit [63:0] total, sq_sum, neff, wv, nv;
      bit        nonzero;
      bit [31:0] top_w;
      status_code_type st;
      n = live_count();
      total = 0;
      sq_sum = 0;
      nonzero = 0;
      top_w = 0;
      st = ST_OK;
      for (int i = 0; i < n; i++) total += weights[i];
      for (int i = 0; i < n; i++) begin
         wv = weights[i];
         if (total == 0) nv = 0;
         else if (wv >= total) nv = 64'hFFFF_FFFF;
         else nv = (wv << 32) / total;
         weights[i] = nv[31:0];
         if (nv != 0) nonzero = 1;
         sq_sum += (nv * nv) >> 32;
      end
      if (!nonzero) neff = 0;
      else if (sq_sum == 0) neff = n;
      else begin
         neff = (64'd1 << 32) / sq_sum;
         if (neff > n) neff = n;
      end
      eff_size_q = neff[9:0];
      if (neff * 256 < 64'(n) * cfg_lost_q8) track_lost = 1;
      else if (neff * 256 < 64'(n) * cfg_resample_q8) st = ST_RESAMPLE;
      if (track_lost) st = ST_LOST;
      else begin
         for (int i = 0; i < n; i++) begin
            if (weights[i] > top_w) begin
               top_w = weights[i];
               best_pick = i[8:0];
            end
         end
      end
      return st;
   endfunction

   function automatic verdict_type predict_word(word_type wd);
      verdict_type res;
      bit [63:0]   prod, r;
      int          n, pick;
      res = '{ST_OK, 9'd0, 32'd0, 10'd0, 9'd0};
      case (wd.kind)
         REQ_LOAD: begin
            weights[wd.index] = wd.weight;
            track_lost = 0;
         end
         REQ_REWEIGHT: begin
            prod = 64'(weights[wd.index]) * 64'(wd.likelihood);
            weights[wd.index] = prod[47:16];
            if (wd.pass_end) res.status = close_pass();
         end
         REQ_DRAW: begin
            n = live_count();
            pick = n - 1;
            r = wd.uniform;
            for (int i = 0; i < n; i++) begin
               if (r <= weights[i]) begin
                  pick = i;
                  break;
               end
               r -= weights[i];
            end
            res.status = ST_DRAW;
            res.picked_index = pick[8:0];
            res.picked_weight = weights[pick];
         end
         default: ;
      endcase
      res.eff_size = eff_size_q;
      res.best = best_pick;
      return res;
   endfunction

   // check each result word against the oldest expectation
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10) $display("unexpected result word, status %0d", rsp_status);
         end else begin
            want = pending_q.pop_front();
            if (rsp_status !== want.status || rsp_picked_index !== want.picked_index ||
                rsp_picked_weight !== want.picked_weight ||
                rsp_effective_size !== want.eff_size || rsp_best_index !== want.best) begin
               err_cnt++;
               if (err_cnt <= 10)
                  $display({"mismatch: exp st %0d idx %0d w %h eff %0d best %0d",
                            " / got st %0d idx %0d w %h eff %0d best %0d"},
                           want.status, want.picked_index, want.picked_weight,
                           want.eff_size, want.best, rsp_status, rsp_picked_index,
                           rsp_picked_weight, rsp_effective_size, rsp_best_index);
            end
         end
      end
   end

   // present one word after a random gap, hold until accepted
   task automatic send_word(word_type wd, bit typed, verdict_type typed_res);
      int          gap;
      verdict_type res;
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_type <= wd.kind;
      req_particle_index <= wd.index;
      req_weight_in <= wd.weight;
      req_likelihood_in <= wd.likelihood;
      req_uniform_in <= wd.uniform;
      req_pass_end <= wd.pass_end;
      do @(posedge clock); while (busy);
      res = predict_word(wd);
      pending_q = {pending_q, (typed ? typed_res : res)};
      words_sent++;
   endtask

   // drop start, then write a register once the block has drained
   task automatic write_reg(logic [1:0] sel, bit [9:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_data <= value;
      @(posedge clock);
      case (sel)
         CSR_ACTIVE:   cfg_active = value;
         CSR_LOST:     cfg_lost_q8 = value[7:0];
         CSR_RESAMPLE: cfg_resample_q8 = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic word_type mk(req_code_type k, int idx, bit [31:0] w, bit [15:0] l,
                                   bit [31:0] u, bit pe);
      word_type wd;
      wd.kind = k;
      wd.index = idx[8:0];
      wd.weight = w;
      wd.likelihood = l;
      wd.uniform = u;
      wd.pass_end = pe;
      return wd;
   endfunction

   task automatic add_row(word_type wd, bit typed = 0);
      row_type r;
      r.is_csr = 0;
      r.csr_sel = CSR_ACTIVE;
      r.csr_value = 0;
      r.wd = wd;
      r.typed = typed;
      r.typed_res = '{ST_OK, 9'd0, 32'd0, 10'd0, 9'd0};
      stim_table = {stim_table, r};
   endtask

   task automatic add_csr(logic [1:0] sel, bit [9:0] value);
      row_type r;
      r = '{1'b1, sel, value, mk(REQ_NONE, 0, 0, 0, 0, 0), 1'b0,
            '{ST_OK, 9'd0, 32'd0, 10'd0, 9'd0}};
      stim_table = {stim_table, r};
   endtask

   function automatic bit [31:0] pick_weight(int style);
      case (style)
         0: return $urandom();
         1: return ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
         2: return $urandom_range(0, 255);
         default: return ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 15);
      endcase
   endfunction

   function automatic bit [15:0] pick_likelihood();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic word_type noise_word();
      return mk(req_code_type'($urandom_range(0, 3)), $urandom_range(0, NPART - 1), $urandom(),
                $urandom_range(0, 65535), $urandom(), $urandom_range(0, 1));
   endfunction

   // one configuration: loads, a reweight pass closed by pass end, draws, some noise
   task automatic run_setting(bit [9:0] active, bit [7:0] lostf, bit [7:0] resf, int words);
      verdict_type dummy;
      int          n, k, style, done;
      dummy = '{ST_OK, 9'd0, 32'd0, 10'd0, 9'd0};
      write_reg(CSR_ACTIVE, active);
      write_reg(CSR_LOST, {2'b00, lostf});
      write_reg(CSR_RESAMPLE, {2'b00, resf});
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
      n = live_count();
      done = 0;
      while (done < words) begin
         style = $urandom_range(0, 3);
         k = (n < 12) ? n : $urandom_range(1, 12);
         for (int i = 0; i < k; i++)
            send_word(mk(REQ_LOAD, (k == n) ? i : $urandom_range(0, n - 1),
                         pick_weight(style), 0, $urandom(), $urandom_range(0, 1)), 0, dummy);
         k = $urandom_range(1, 6);
         for (int i = 0; i < k; i++)
            send_word(mk(REQ_REWEIGHT, $urandom_range(0, n - 1), $urandom(), pick_likelihood(),
                         $urandom(), i == k - 1), 0, dummy);
         k = $urandom_range(1, 6);
         for (int i = 0; i < k; i++)
            send_word(mk(REQ_DRAW, $urandom_range(0, NPART - 1), $urandom(), 0,
                         $urandom() >> $urandom_range(0, 12), 0), 0, dummy);
         if ($urandom_range(0, 2) == 0) send_word(noise_word(), 0, dummy);
         done += 16;
      end
   endtask

   initial begin
      verdict_type dummy;
      bit [9:0]    act;
      dummy = '{ST_OK, 9'd0, 32'd0, 10'd0, 9'd0};
      for (int i = 0; i < NPART; i++) weights[i] = 0;
      track_lost = 0;
      best_pick = 0;
      eff_size_q = 0;
      cfg_active = 500;
      cfg_lost_q8 = 10;
      cfg_resample_q8 = 192;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every weight so no read ever hits an unwritten entry
      gap_max = 2;
      for (int i = 0; i < NPART; i++)
         send_word(mk(REQ_LOAD, i, $urandom(), 0, 0, 0), 0, dummy);

      // directed table: extremes, every request, zero sum, draw past the total
      add_row(mk(REQ_LOAD, 0, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 1), 1);
      add_row(mk(REQ_LOAD, 511, 32'hFFFF_FFFF, 0, 0, 0), 1);
      add_row(mk(REQ_NONE, 511, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1), 1);
      add_row(mk(REQ_REWEIGHT, 5, 0, 16'd0, 0, 0), 1);
      add_row(mk(REQ_REWEIGHT, 511, 0, 16'hFFFF, 0, 0), 1);
      add_row(mk(REQ_DRAW, 0, 0, 0, 32'd0, 0));
      add_row(mk(REQ_DRAW, 0, 0, 0, 32'hFFFF_FFFF, 0));
      add_row(mk(REQ_REWEIGHT, 3, 0, 16'h8000, 0, 1));
      add_row(mk(REQ_DRAW, 0, 0, 0, 32'h8000_0000, 0));
      add_csr(CSR_ACTIVE, 10'd512);
      add_row(mk(REQ_REWEIGHT, 0, 0, 16'hFFFF, 0, 1));
      add_row(mk(REQ_DRAW, 0, 0, 0, 32'hFFFF_FFFF, 0));
      add_csr(CSR_ACTIVE, 10'd1);
      add_row(mk(REQ_LOAD, 0, 32'd0, 0, 0, 0));
      add_row(mk(REQ_REWEIGHT, 0, 0, 16'hFFFF, 0, 1));
      add_row(mk(REQ_DRAW, 0, 0, 0, 32'hFFFF_FFFF, 0));
      add_csr(CSR_ACTIVE, 10'd0);
      add_row(mk(REQ_LOAD, 0, 32'h8000_0000, 0, 0, 0));
      add_row(mk(REQ_REWEIGHT, 0, 0, 16'hFFFF, 0, 1));
      add_csr(CSR_ACTIVE, 10'd1023);
      add_row(mk(REQ_REWEIGHT, 100, 0, 16'h1234, 0, 1));
      add_csr(CSR_LOST, 10'd255);
      add_csr(CSR_RESAMPLE, 10'd255);
      add_row(mk(REQ_LOAD, 7, 32'h0000_FFFF, 0, 0, 0));
      add_row(mk(REQ_REWEIGHT, 7, 0, 16'hFFFF, 0, 1));
      add_csr(CSR_LOST, 10'd0);
      add_csr(CSR_RESAMPLE, 10'd0);
      add_row(mk(REQ_REWEIGHT, 9, 0, 16'h7FFF, 0, 1));

      gap_max = 18;
      foreach (stim_table[i]) begin
         if (stim_table[i].is_csr) write_reg(stim_table[i].csr_sel, stim_table[i].csr_value);
         else send_word(stim_table[i].wd, stim_table[i].typed, stim_table[i].typed_res);
      end

      // a couple of full-size settings, then mostly small particle counts
      run_setting(10'd512, 8'd10, 8'd192, 16);
      run_setting(10'd1023, 8'd255, 8'd0, 16);
      while (words_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 9))
            0: act = 10'd1;
            1: act = 10'd0;
            2: act = $urandom_range(100, 200);
            default: act = $urandom_range(2, 24);
         endcase
         run_setting(act, $urandom_range(0, 255), $urandom_range(0, 255), 32);
      end

      // drop start, drain and let any stray word show up
      @(negedge clock);
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (err_cnt == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/pwr_pkg.sv
rtl/pwr_ram.sv
rtl/particle_weight_resampler_unit.sv
rtl/pwr_checker.sv
verif/testbench.sv
